### hw/rtl/fjsop_pkg.sv
// Package with the types, character codes and helper functions of the JSON object parser.
`timescale 1ns / 1ps

package fjsop_pkg;

    localparam logic [7:0] CH_LBRACE    = 8'h7B;
    localparam logic [7:0] CH_RBRACE    = 8'h7D;
    localparam logic [7:0] CH_COLON     = 8'h3A;
    localparam logic [7:0] CH_COMMA     = 8'h2C;
    localparam logic [7:0] CH_QUOTE     = 8'h22;
    localparam logic [7:0] CH_BACKSLASH = 8'h5C;
    localparam logic [7:0] CH_SLASH     = 8'h2F;
    localparam logic [7:0] CH_BS        = 8'h08;
    localparam logic [7:0] CH_FF        = 8'h0C;
    localparam logic [7:0] CH_LF        = 8'h0A;
    localparam logic [7:0] CH_CR        = 8'h0D;
    localparam logic [7:0] CH_TAB       = 8'h09;
    localparam logic [7:0] CH_SPACE     = 8'h20;
    localparam logic [7:0] CH_LOW_B     = 8'h62;
    localparam logic [7:0] CH_LOW_F     = 8'h66;
    localparam logic [7:0] CH_LOW_N     = 8'h6E;
    localparam logic [7:0] CH_LOW_R     = 8'h72;
    localparam logic [7:0] CH_LOW_T     = 8'h74;

    typedef enum logic [3:0] {
        PH_OPEN       = 4'd0,
        PH_FIRST      = 4'd1,
        PH_KEYSTART_C = 4'd2,
        PH_KEYSTART_W = 4'd3,
        PH_KEY        = 4'd4,
        PH_KEY_ESC    = 4'd5,
        PH_COLON      = 4'd6,
        PH_VALSTART   = 4'd7,
        PH_VAL        = 4'd8,
        PH_VAL_ESC    = 4'd9,
        PH_SEP        = 4'd10,
        PH_TAIL       = 4'd11
    } t_phase;

    typedef enum logic [2:0] {
        KIND_KEY     = 3'd0,
        KIND_VAL     = 3'd1,
        KIND_KEYEND  = 3'd2,
        KIND_VALEND  = 3'd3,
        KIND_STATUS  = 3'd4
    } t_kind;

    typedef enum logic [3:0] {
        ST_OK        = 4'd0,
        ST_NO_OBJ    = 4'd1,
        ST_NO_COLON  = 4'd2,
        ST_NO_STR    = 4'd3,
        ST_NO_SEP    = 4'd4,
        ST_TRAILING  = 4'd5,
        ST_OPEN_OBJ  = 4'd6,
        ST_OPEN_STR  = 4'd7,
        ST_OPEN_ESC  = 4'd8,
        ST_BAD_ESC   = 4'd9
    } t_status;

    typedef struct packed {
        t_phase phase;
        logic   failed;
    } t_state;

    typedef struct packed {
        t_kind      kind;
        logic [7:0] out_byte;
        t_status    status;
        logic       last_of_run;
    } t_result;

    typedef struct packed {
        logic       ok;
        logic [7:0] chr;
    } t_unesc;

    function automatic logic is_ws(input logic [7:0] c);
        return (c == CH_SPACE) || ((c >= CH_TAB) && (c <= CH_CR));
    endfunction

    function automatic t_unesc unescape(input logic [7:0] c);
        t_unesc u;
        u.ok  = 1'b1;
        u.chr = c;
        case (c)
            CH_QUOTE, CH_BACKSLASH, CH_SLASH: u.chr = c;
            CH_LOW_B: u.chr = CH_BS;
            CH_LOW_F: u.chr = CH_FF;
            CH_LOW_N: u.chr = CH_LF;
            CH_LOW_R: u.chr = CH_CR;
            CH_LOW_T: u.chr = CH_TAB;
            default: begin
                u.ok  = 1'b0;
                u.chr = 8'h00;
            end
        endcase
        return u;
    endfunction

    // Status given when the document ends in the given phase.
    function automatic t_status end_status(input t_phase p);
        t_status s;
        case (p)
            PH_OPEN:       s = ST_NO_OBJ;
            PH_FIRST:      s = ST_OPEN_OBJ;
            PH_KEYSTART_C: s = ST_OPEN_OBJ;
            PH_KEYSTART_W: s = ST_NO_STR;
            PH_KEY:        s = ST_OPEN_STR;
            PH_KEY_ESC:    s = ST_OPEN_ESC;
            PH_COLON:      s = ST_NO_COLON;
            PH_VALSTART:   s = ST_NO_STR;
            PH_VAL:        s = ST_OPEN_STR;
            PH_VAL_ESC:    s = ST_OPEN_ESC;
            PH_SEP:        s = ST_NO_SEP;
            PH_TAIL:       s = ST_OK;
            default:       s = ST_NO_OBJ;
        endcase
        return s;
    endfunction

endpackage

### hw/rtl/fjsop_in_if.sv
// Input channel interface: one raw document byte and its end flag per item.
`timescale 1ns / 1ps

interface fjsop_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       end_of_doc;

    modport source (output valid, output data_byte, output end_of_doc, input ready);
    modport sink   (input valid, input data_byte, input end_of_doc, output ready);
endinterface

### hw/rtl/fjsop_out_if.sv
// Output channel interface: one decoded byte, end mark or status per item.
`timescale 1ns / 1ps

interface fjsop_out_if;
    logic       valid;
    logic       ready;
    logic [2:0] kind;
    logic [7:0] out_byte;
    logic [3:0] status;
    logic       last_of_run;

    modport source (output valid, output kind, output out_byte, output status,
                    output last_of_run, input ready);
    modport sink   (input valid, input kind, input out_byte, input status,
                    input last_of_run, output ready);
endinterface

### hw/rtl/flat_json_string_object_parser.sv
// Top level of the streaming parser for flat JSON objects of string keys and values.
// Registered output: the first result of a byte is offered in the cycle after the byte is accepted.
// Throughput: one byte per cycle while the output is taken; a byte that yields two results holds
// the input until its second result moves from the holding register to the output register.
// Reset: the parser expects an opening brace, the error flag is clear, no result is pending.
`timescale 1ns / 1ps

module flat_json_string_object_parser
    import fjsop_pkg::*;
(
    input  logic          i_clk,
    input  logic          i_rst_n,
    fjsop_in_if.sink      i_in,
    fjsop_out_if.source   o_out
);

    t_state     r_state;
    t_state     n_state;
    logic       r_out_valid;
    t_result    r_out;
    logic       r_hold_valid;
    t_result    r_hold;
    logic [1:0] step_count;
    t_result    step_res0;
    t_result    step_res1;
    logic       out_take;
    logic       in_acc;

    fjsop_step u_step (
        .i_state      (r_state),
        .i_data_byte  (i_in.data_byte),
        .i_end_of_doc (i_in.end_of_doc),
        .o_state      (n_state),
        .o_count      (step_count),
        .o_res0       (step_res0),
        .o_res1       (step_res1)
    );

    assign out_take   = r_out_valid && o_out.ready;
    assign i_in.ready = !r_hold_valid && (!r_out_valid || out_take);
    assign in_acc     = i_in.valid && i_in.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state.phase  <= PH_OPEN;
            r_state.failed <= 1'b0;
            r_out_valid    <= 1'b0;
            r_hold_valid   <= 1'b0;
        end else begin
            if (in_acc) begin
                r_state <= n_state;
            end
            if (r_hold_valid && out_take) begin
                r_out_valid  <= 1'b1;
                r_hold_valid <= 1'b0;
            end else if (in_acc) begin
                r_out_valid  <= (step_count != 2'd0);
                r_hold_valid <= (step_count == 2'd2);
            end else if (out_take) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_hold_valid && out_take) begin
            r_out <= r_hold;
        end else if (in_acc) begin
            r_out  <= step_res0;
            r_hold <= step_res1;
        end
    end

    assign o_out.valid       = r_out_valid;
    assign o_out.kind        = r_out.kind;
    assign o_out.out_byte    = r_out.out_byte;
    assign o_out.status      = r_out.status;
    assign o_out.last_of_run = r_out.last_of_run;

endmodule

### hw/rtl/fjsop_step.sv
// Combinational grammar step: next parser state and up to two results for one byte.
`timescale 1ns / 1ps

module fjsop_step
    import fjsop_pkg::*;
(
    input  t_state     i_state,
    input  logic [7:0] i_data_byte,
    input  logic       i_end_of_doc,
    output t_state     o_state,
    output logic [1:0] o_count,
    output t_result    o_res0,
    output t_result    o_res1
);

    t_phase     eff_phase;
    t_phase     nxt_phase;
    logic       ws;
    logic       has_data;
    t_kind      data_kind;
    logic [7:0] data_byte;
    logic       err;
    t_status    err_code;
    t_unesc     esc;
    logic       is_key;
    logic       has_stat;
    t_status    stat_code;
    t_result    data_res;
    t_result    stat_res;

    assign ws  = is_ws(i_data_byte);
    assign esc = unescape(i_data_byte);

    always_comb begin
        // Codes past the tail phase never arise; they act as the reset phase.
        eff_phase = (i_state.phase > PH_TAIL) ? PH_OPEN : i_state.phase;
        nxt_phase = eff_phase;
        has_data  = 1'b0;
        data_kind = KIND_KEY;
        data_byte = 8'h00;
        err       = 1'b0;
        err_code  = ST_OK;
        is_key    = (eff_phase == PH_KEY) || (eff_phase == PH_KEY_ESC);

        case (eff_phase)
            PH_OPEN: begin
                if (i_data_byte == CH_LBRACE) begin
                    nxt_phase = PH_FIRST;
                end else if (!ws) begin
                    err = 1'b1; err_code = ST_NO_OBJ;
                end
            end
            PH_FIRST: begin
                if (i_data_byte == CH_RBRACE) begin
                    nxt_phase = PH_TAIL;
                end else if (i_data_byte == CH_QUOTE) begin
                    nxt_phase = PH_KEY;
                end else if (!ws) begin
                    err = 1'b1; err_code = ST_NO_STR;
                end
            end
            PH_KEYSTART_C, PH_KEYSTART_W: begin
                if (i_data_byte == CH_QUOTE) begin
                    nxt_phase = PH_KEY;
                end else if (ws) begin
                    nxt_phase = PH_KEYSTART_W;
                end else begin
                    err = 1'b1; err_code = ST_NO_STR;
                end
            end
            PH_KEY, PH_VAL: begin
                has_data = 1'b1;
                if (i_data_byte == CH_QUOTE) begin
                    data_kind = is_key ? KIND_KEYEND : KIND_VALEND;
                    nxt_phase = is_key ? PH_COLON : PH_SEP;
                end else if (i_data_byte == CH_BACKSLASH) begin
                    has_data  = 1'b0;
                    nxt_phase = is_key ? PH_KEY_ESC : PH_VAL_ESC;
                end else begin
                    data_kind = is_key ? KIND_KEY : KIND_VAL;
                    data_byte = i_data_byte;
                end
            end
            PH_KEY_ESC, PH_VAL_ESC: begin
                if (esc.ok) begin
                    has_data  = 1'b1;
                    data_kind = is_key ? KIND_KEY : KIND_VAL;
                    data_byte = esc.chr;
                    nxt_phase = is_key ? PH_KEY : PH_VAL;
                end else begin
                    err = 1'b1; err_code = ST_BAD_ESC;
                end
            end
            PH_COLON: begin
                if (i_data_byte == CH_COLON) begin
                    nxt_phase = PH_VALSTART;
                end else if (!ws) begin
                    err = 1'b1; err_code = ST_NO_COLON;
                end
            end
            PH_VALSTART: begin
                if (i_data_byte == CH_QUOTE) begin
                    nxt_phase = PH_VAL;
                end else if (!ws) begin
                    err = 1'b1; err_code = ST_NO_STR;
                end
            end
            PH_SEP: begin
                if (i_data_byte == CH_RBRACE) begin
                    nxt_phase = PH_TAIL;
                end else if (i_data_byte == CH_COMMA) begin
                    nxt_phase = PH_KEYSTART_C;
                end else if (!ws) begin
                    err = 1'b1; err_code = ST_NO_SEP;
                end
            end
            default: begin
                if (!ws) begin
                    err = 1'b1; err_code = ST_TRAILING;
                end
            end
        endcase

        has_stat  = err || i_end_of_doc;
        stat_code = err ? err_code : end_status(nxt_phase);

        data_res.kind        = data_kind;
        data_res.out_byte    = data_byte;
        data_res.status      = ST_OK;
        data_res.last_of_run = !has_stat;

        stat_res.kind        = KIND_STATUS;
        stat_res.out_byte    = 8'h00;
        stat_res.status      = stat_code;
        stat_res.last_of_run = 1'b1;

        o_res0  = has_data ? data_res : stat_res;
        o_res1  = stat_res;
        o_count = {1'b0, has_data} + {1'b0, has_stat};

        o_state.phase  = (has_stat && i_end_of_doc) ? PH_OPEN : nxt_phase;
        o_state.failed = err && !i_end_of_doc;

        // Once an error status is out, bytes up to and including the end-flagged one are dropped.
        if (i_state.failed) begin
            o_count        = 2'd0;
            o_state.failed = !i_end_of_doc;
            o_state.phase  = i_end_of_doc ? PH_OPEN : i_state.phase;
        end
    end

endmodule

### verif/flat_json_string_object_parser_tb.sv
// Self-checking testbench of the streaming flat JSON string object parser.
`timescale 1ns / 1ps

module flat_json_string_object_parser_tb;
    import fjsop_pkg::*;

    localparam int STALL_LIMIT = 5000;
    localparam int DIRECTED_BYTES = 24;
    localparam int BYTES_PER_PHASE = 283;

    // Idling profiles, in the order the run goes through them.
    localparam logic [1:0] MODE_RX_SLOW = 2'd0;
    localparam logic [1:0] MODE_TX_SLOW = 2'd1;
    localparam logic [1:0] MODE_FULL    = 2'd2;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       end_of_doc;
        logic [1:0] mode;
        logic       drain;
    } t_pending_byte;

    logic i_clk;
    logic i_rst_n;

    fjsop_in_if  in_ch ();
    fjsop_out_if out_ch ();

    flat_json_string_object_parser dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch)
    );

    t_pending_byte byte_q[$];
    t_result       decoded_q[$];
    logic [7:0]    doc_buf[$];

    // Shadow of the parser state.
    t_phase grammar_phase = PH_OPEN;
    logic   doc_failed = 1'b0;

    int   rx_idle_pct = 70;
    int   err_count = 0;
    int   bytes_in = 0;
    int   results_seen = 0;
    int   docs_built = 0;
    int   stall_cycles = 0;
    logic [9:0] status_seen = '0;

    t_pending_byte next_byte;

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    function automatic int tx_idle_of(input logic [1:0] mode);
        case (mode)
            MODE_RX_SLOW: return 29;
            MODE_TX_SLOW: return 70;
            default:      return 0;
        endcase
    endfunction

    function automatic int rx_idle_of(input logic [1:0] mode);
        case (mode)
            MODE_RX_SLOW: return 70;
            MODE_TX_SLOW: return 29;
            default:      return 0;
        endcase
    endfunction

    function automatic logic blank_char(input logic [7:0] c);
        return (c == CH_SPACE) || (c >= CH_TAB && c <= CH_CR);
    endfunction

    // Returns {supported, decoded character} for the letter after a backslash.
    function automatic logic [8:0] escaped_char(input logic [7:0] c);
        case (c)
            CH_QUOTE, CH_BACKSLASH, CH_SLASH: return {1'b1, c};
            CH_LOW_B: return {1'b1, CH_BS};
            CH_LOW_F: return {1'b1, CH_FF};
            CH_LOW_N: return {1'b1, CH_LF};
            CH_LOW_R: return {1'b1, CH_CR};
            CH_LOW_T: return {1'b1, CH_TAB};
            default:  return 9'h000;
        endcase
    endfunction

    function automatic t_result make_result(input t_kind k, input logic [7:0] b,
                                            input t_status s);
        t_result r;
        r.kind        = k;
        r.out_byte    = b;
        r.status      = s;
        r.last_of_run = 1'b0;
        return r;
    endfunction

    // Advances the shadow state by one document byte and queues its results.
    task automatic decode_byte(input logic [7:0] b, input logic eod);
        t_result    res [2];
        int         n;
        logic       err;
        t_status    code;
        logic [8:0] esc;
        logic       in_key;
        n    = 0;
        err  = 1'b0;
        code = ST_OK;
        if (doc_failed) begin
            if (eod) begin
                doc_failed    = 1'b0;
                grammar_phase = PH_OPEN;
            end
            return;
        end
        case (grammar_phase)
            PH_OPEN: begin
                if (b == CH_LBRACE) grammar_phase = PH_FIRST;
                else if (!blank_char(b)) begin err = 1'b1; code = ST_NO_OBJ; end
            end
            PH_FIRST: begin
                if (b == CH_RBRACE) grammar_phase = PH_TAIL;
                else if (b == CH_QUOTE) grammar_phase = PH_KEY;
                else if (!blank_char(b)) begin err = 1'b1; code = ST_NO_STR; end
            end
            PH_KEYSTART_C, PH_KEYSTART_W: begin
                if (b == CH_QUOTE) grammar_phase = PH_KEY;
                else if (blank_char(b)) grammar_phase = PH_KEYSTART_W;
                else begin err = 1'b1; code = ST_NO_STR; end
            end
            PH_KEY, PH_VAL: begin
                in_key = (grammar_phase == PH_KEY);
                if (b == CH_QUOTE) begin
                    res[n] = make_result(in_key ? KIND_KEYEND : KIND_VALEND, 8'h00, ST_OK);
                    n++;
                    grammar_phase = in_key ? PH_COLON : PH_SEP;
                end else if (b == CH_BACKSLASH) begin
                    grammar_phase = in_key ? PH_KEY_ESC : PH_VAL_ESC;
                end else begin
                    res[n] = make_result(in_key ? KIND_KEY : KIND_VAL, b, ST_OK);
                    n++;
                end
            end
            PH_KEY_ESC, PH_VAL_ESC: begin
                in_key = (grammar_phase == PH_KEY_ESC);
                esc = escaped_char(b);
                if (esc[8]) begin
                    res[n] = make_result(in_key ? KIND_KEY : KIND_VAL, esc[7:0], ST_OK);
                    n++;
                    grammar_phase = in_key ? PH_KEY : PH_VAL;
                end else begin
                    err = 1'b1;
                    code = ST_BAD_ESC;
                end
            end
            PH_COLON: begin
                if (b == CH_COLON) grammar_phase = PH_VALSTART;
                else if (!blank_char(b)) begin err = 1'b1; code = ST_NO_COLON; end
            end
            PH_VALSTART: begin
                if (b == CH_QUOTE) grammar_phase = PH_VAL;
                else if (!blank_char(b)) begin err = 1'b1; code = ST_NO_STR; end
            end
            PH_SEP: begin
                if (b == CH_RBRACE) grammar_phase = PH_TAIL;
                else if (b == CH_COMMA) grammar_phase = PH_KEYSTART_C;
                else if (!blank_char(b)) begin err = 1'b1; code = ST_NO_SEP; end
            end
            default: begin
                if (!blank_char(b)) begin err = 1'b1; code = ST_TRAILING; end
            end
        endcase

        if (err) begin
            res[n] = make_result(KIND_STATUS, 8'h00, code);
            n++;
            if (eod) grammar_phase = PH_OPEN;
            else doc_failed = 1'b1;
        end else if (eod) begin
            case (grammar_phase)
                PH_OPEN:                    code = ST_NO_OBJ;
                PH_FIRST, PH_KEYSTART_C:    code = ST_OPEN_OBJ;
                PH_KEYSTART_W, PH_VALSTART: code = ST_NO_STR;
                PH_KEY, PH_VAL:             code = ST_OPEN_STR;
                PH_KEY_ESC, PH_VAL_ESC:     code = ST_OPEN_ESC;
                PH_COLON:                   code = ST_NO_COLON;
                PH_SEP:                     code = ST_NO_SEP;
                default:                    code = ST_OK;
            endcase
            res[n] = make_result(KIND_STATUS, 8'h00, code);
            n++;
            grammar_phase = PH_OPEN;
        end

        if (n > 0) res[n-1].last_of_run = 1'b1;
        for (int i = 0; i < n; i++) decoded_q = {decoded_q, res[i]};
    endtask

    task automatic check_result();
        t_result want;
        results_seen++;
        if (decoded_q.size() == 0) begin
            $error("unexpected result: kind %0d byte 0x%02h status %0d last %0b",
                   out_ch.kind, out_ch.out_byte, out_ch.status, out_ch.last_of_run);
            err_count++;
            return;
        end
        want = decoded_q.pop_front();
        if (out_ch.kind !== want.kind) begin
            $error("kind: expected %0d, got %0d", want.kind, out_ch.kind);
            err_count++;
        end
        if (out_ch.out_byte !== want.out_byte) begin
            $error("out_byte: expected 0x%02h, got 0x%02h", want.out_byte, out_ch.out_byte);
            err_count++;
        end
        if (out_ch.status !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, out_ch.status);
            err_count++;
        end
        if (out_ch.last_of_run !== want.last_of_run) begin
            $error("last_of_run: expected %0b, got %0b", want.last_of_run,
                   out_ch.last_of_run);
            err_count++;
        end
        if (want.kind == KIND_STATUS) status_seen[want.status] = 1'b1;
    endtask

    // Prediction runs before checking, so a byte's results are queued before they can appear.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (in_ch.valid && in_ch.ready) begin
                decode_byte(in_ch.data_byte, in_ch.end_of_doc);
                bytes_in++;
            end
            if (out_ch.valid && out_ch.ready) check_result();
        end
    end

    // Byte driver. An item flagged for draining waits until the parser has nothing left to give.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            in_ch.valid <= 1'b0;
        end else if (!in_ch.valid || in_ch.ready) begin
            if (byte_q.size() == 0) begin
                in_ch.valid <= 1'b0;
            end else if (byte_q[0].drain && (in_ch.valid || decoded_q.size() != 0)) begin
                in_ch.valid <= 1'b0;
            end else if ($urandom_range(0, 99) >= tx_idle_of(byte_q[0].mode)) begin
                next_byte = byte_q.pop_front();
                in_ch.valid      <= 1'b1;
                in_ch.data_byte  <= next_byte.data_byte;
                in_ch.end_of_doc <= next_byte.end_of_doc;
                rx_idle_pct      <= rx_idle_of(next_byte.mode);
            end else begin
                in_ch.valid <= 1'b0;
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n) out_ch.ready <= 1'b0;
        else out_ch.ready <= ($urandom_range(0, 99) >= rx_idle_pct);
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
                stall_cycles <= 0;
            end else if (stall_cycles >= STALL_LIMIT) begin
                $display("watchdog: no item moved for %0d cycles", STALL_LIMIT);
                $display("[flat_json_string_object_parser] ERROR");
                $finish;
            end else begin
                stall_cycles <= stall_cycles + 1;
            end
        end
    end

    // Appends one byte to the document being built.
    task automatic add_byte(input logic [7:0] c);
        doc_buf = {doc_buf, c};
    endtask

    task automatic put_str(input string s);
        for (int i = 0; i < s.len(); i++) add_byte(s[i]);
    endtask

    task automatic put_blank();
        logic [7:0] blanks [6];
        int n;
        blanks = '{CH_SPACE, CH_TAB, CH_LF, 8'h0B, CH_FF, CH_CR};
        n = ($urandom_range(0, 2) == 0) ? $urandom_range(1, 2) : 0;
        for (int i = 0; i < n; i++) add_byte(blanks[$urandom_range(0, 5)]);
    endtask

    // Quoted string with random bytes and the supported escapes.
    task automatic put_text();
        logic [7:0] letters [8];
        logic [7:0] c;
        int len;
        letters = '{CH_QUOTE, CH_BACKSLASH, CH_SLASH, CH_LOW_B, CH_LOW_F, CH_LOW_N,
                    CH_LOW_R, CH_LOW_T};
        len = $urandom_range(0, 4);
        add_byte(CH_QUOTE);
        for (int i = 0; i < len; i++) begin
            if ($urandom_range(0, 9) < 2) begin
                add_byte(CH_BACKSLASH);
                add_byte(letters[$urandom_range(0, 7)]);
            end else begin
                c = 8'($urandom_range(0, 255));
                if (c == CH_QUOTE || c == CH_BACKSLASH) c = 8'h41;
                add_byte(c);
            end
        end
        add_byte(CH_QUOTE);
    endtask

    task automatic flush_doc(input logic [1:0] mode, input logic drain);
        t_pending_byte p;
        for (int i = 0; i < doc_buf.size(); i++) begin
            p.data_byte  = doc_buf[i];
            p.end_of_doc = (i == doc_buf.size() - 1);
            p.mode       = mode;
            p.drain      = drain && (i == 0);
            byte_q = {byte_q, p};
        end
        doc_buf.delete();
        docs_built++;
    endtask

    task automatic build_random_doc(input logic [1:0] mode, input logic drain);
        logic [7:0] marks [8];
        int pairs;
        int r;
        int idx;
        int keep;
        marks = '{CH_LBRACE, CH_RBRACE, CH_COLON, CH_COMMA, CH_QUOTE, CH_BACKSLASH,
                  CH_SPACE, 8'h75};
        r = $urandom_range(0, 99);
        if (r < 5) begin
            // Pure noise.
            repeat ($urandom_range(1, 4)) add_byte(8'($urandom_range(0, 255)));
        end else begin
            put_blank();
            add_byte(CH_LBRACE);
            put_blank();
            pairs = $urandom_range(0, 3);
            for (int i = 0; i < pairs; i++) begin
                if (i > 0) begin
                    add_byte(CH_COMMA);
                    put_blank();
                end
                put_text();
                put_blank();
                add_byte(CH_COLON);
                put_blank();
                put_text();
                put_blank();
            end
            add_byte(CH_RBRACE);
            put_blank();
            r = $urandom_range(0, 99);
            if (r < 20) begin
                keep = $urandom_range(1, doc_buf.size());
                while (doc_buf.size() > keep) void'(doc_buf.pop_back());
            end else if (r < 35) begin
                idx = $urandom_range(0, doc_buf.size() - 1);
                if ($urandom_range(0, 1) == 0) doc_buf[idx] = marks[$urandom_range(0, 7)];
                else doc_buf[idx] = 8'($urandom_range(0, 255));
            end else if (r < 42) begin
                add_byte(8'($urandom_range(0, 255)));
                put_blank();
            end
        end
        flush_doc(mode, drain);
    endtask

    initial begin
        in_ch.valid      = 1'b0;
        in_ch.data_byte  = 8'h00;
        in_ch.end_of_doc = 1'b0;
        out_ch.ready     = 1'b0;
        i_rst_n          = 1'b0;

        // Extreme bytes as key and value, then the empty object with a trailing byte.
        put_str("{\"");
        add_byte(8'hFF);
        put_str("\":\"");
        add_byte(8'h00);
        put_str("\"}");
        flush_doc(MODE_RX_SLOW, 1'b0);
        put_str("{}x");
        flush_doc(MODE_RX_SLOW, 1'b0);
        // Bad escape; the following byte ends the document and is ignored.
        put_str("{\"\\qz");
        flush_doc(MODE_RX_SLOW, 1'b0);
        // An error on the last byte of a document.
        put_str(",");
        flush_doc(MODE_RX_SLOW, 1'b0);
        put_str("{");
        flush_doc(MODE_RX_SLOW, 1'b0);
        put_str(" {\"a\\");
        flush_doc(MODE_RX_SLOW, 1'b0);

        for (int m = 0; m < 3; m++) begin
            build_random_doc(m[1:0], 1'b1);
            while (byte_q.size() < DIRECTED_BYTES + BYTES_PER_PHASE * (m + 1))
                build_random_doc(m[1:0], 1'b0);
        end

        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (byte_q.size() != 0 || in_ch.valid) @(posedge i_clk);
        while (decoded_q.size() != 0) @(posedge i_clk);
        repeat (10) @(posedge i_clk);
        if (decoded_q.size() != 0) begin
            $error("%0d expected results never arrived", decoded_q.size());
            err_count++;
        end

        $display("Fed %0d bytes in %0d documents under three idling profiles.",
                 bytes_in, docs_built);
        $display("Checked %0d results; %0d of 10 status codes occurred.",
                 results_seen, $countones(status_seen));
        if (err_count == 0) begin
            $display("[flat_json_string_object_parser] OK");
        end else begin
            $display("[flat_json_string_object_parser] ERROR");
        end
        $finish;
    end

endmodule
